// File: hw/rtl/rtnb_pkg.sv
// ----------------------------------------------------------------------------
// Radix tree node builder package
// Payload types, field widths and codes that are shared across the block.
// ----------------------------------------------------------------------------
package rtnb_pkg;

    localparam int POS_W     = 10;
    localparam int CODE_IN_W = 30;
    localparam int PRIM_W    = 10;
    localparam int PC_W      = 11;
    localparam int KEY_W     = 7;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_BUILD = 1'b1;

    // Register index, taken from paddr[2].
    localparam logic REG_POINT_COUNT = 1'b0;

    localparam logic [PC_W-1:0] PC_RESET = 11'd2;

    // Keys are the common-prefix length plus one, so a neighbour outside the
    // loaded range (prefix length of minus one) encodes as zero.
    localparam logic [KEY_W-1:0] KEY_NONE = '0;

    typedef struct packed {
        logic                 opcode;
        logic [POS_W-1:0]     position;
        logic [CODE_IN_W-1:0] morton_code;
        logic [PRIM_W-1:0]    primitive_id;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]  node_index;
        logic [POS_W-1:0]  left_index;
        logic              left_is_leaf;
        logic [POS_W-1:0]  right_index;
        logic              right_is_leaf;
        logic [PRIM_W-1:0] left_primitive;
        logic [PRIM_W-1:0] right_primitive;
    } t_out_item;

    typedef struct packed {
        logic issue;
        logic in_range;
    } t_probe;

endpackage

// File: hw/rtl/rtnb_if.sv
// ----------------------------------------------------------------------------
// Radix tree node builder channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface rtnb_in_if;
    import rtnb_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface rtnb_out_if;
    import rtnb_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/rtnb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rtnb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/rtnb_prefix_unit.sv
// ----------------------------------------------------------------------------
// Radix tree node builder prefix unit
// Shared compare stage: turns a probed code into a common-prefix key.
// ----------------------------------------------------------------------------
module rtnb_prefix_unit #(
    parameter int IDX_W     = 10,
    parameter int CODE_BITS = 30
) (
    input  logic                     i_clk,
    input  rtnb_pkg::t_probe         i_probe,
    input  logic [IDX_W-1:0]         i_a,
    input  logic [IDX_W-1:0]         i_b,
    input  logic [CODE_BITS-1:0]     i_code_a,
    input  logic [CODE_BITS-1:0]     i_code_b,
    output logic [rtnb_pkg::KEY_W-1:0] o_key
);
    import rtnb_pkg::*;

    localparam int LZC_W = $clog2(CODE_BITS + 1);
    localparam int LZI_W = $clog2(IDX_W + 1);
    localparam logic [KEY_W-1:0] DIFF_BASE = KEY_W'(65 - CODE_BITS);
    localparam logic [KEY_W-1:0] EQ_BASE   = KEY_W'(97 - IDX_W);

    logic [IDX_W-1:0]     r_b;
    logic                 r_in_range;
    logic [KEY_W-1:0]     r_key;
    logic [KEY_W-1:0]     n_key;
    logic [CODE_BITS-1:0] code_x;
    logic [IDX_W-1:0]     idx_x;
    logic [LZC_W-1:0]     lz_code;
    logic [LZI_W-1:0]     lz_idx;

    always_ff @(posedge i_clk) begin
        if (i_probe.issue) begin
            r_b        <= i_b;
            r_in_range <= i_probe.in_range;
        end
        r_key <= n_key;
    end

    assign code_x = i_code_a ^ i_code_b;
    assign idx_x  = i_a ^ r_b;

    always_comb begin
        lz_code = LZC_W'(CODE_BITS);
        for (int k = 0; k < CODE_BITS; k++) begin
            if (code_x[k]) begin
                lz_code = LZC_W'(CODE_BITS - 1 - k);
            end
        end
    end

    always_comb begin
        lz_idx = LZI_W'(IDX_W);
        for (int k = 0; k < IDX_W; k++) begin
            if (idx_x[k]) begin
                lz_idx = LZI_W'(IDX_W - 1 - k);
            end
        end
    end

    // Equal codes fall back on the index distance so duplicates stay ordered.
    always_comb begin
        if (!r_in_range) begin
            n_key = KEY_NONE;
        end else if (code_x != '0) begin
            n_key = DIFF_BASE + KEY_W'(lz_code);
        end else begin
            n_key = EQ_BASE + KEY_W'(lz_idx);
        end
    end

    assign o_key = r_key;

endmodule

// File: hw/rtl/rtnb_sequencer.sv
// ----------------------------------------------------------------------------
// Radix tree node builder sequencer
// Runs the range, binary and split searches for one internal node.
// ----------------------------------------------------------------------------
module rtnb_sequencer #(
    parameter int MAX_POINTS = 1024,
    parameter int CODE_BITS  = 30
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(MAX_POINTS):0]   i_n,
    rtnb_in_if.sink                       i_in,
    rtnb_out_if.source                    o_out,
    output logic [$clog2(MAX_POINTS)-1:0] o_code_raddr,
    input  logic [CODE_BITS-1:0]          i_code_rdata,
    output logic [$clog2(MAX_POINTS)-1:0] o_prim_raddr,
    input  logic [rtnb_pkg::PRIM_W-1:0]   i_prim_rdata,
    output rtnb_pkg::t_probe              o_probe,
    output logic [$clog2(MAX_POINTS)-1:0] o_i,
    output logic [CODE_BITS-1:0]          o_code_i,
    input  logic [rtnb_pkg::KEY_W-1:0]    i_key
);
    import rtnb_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int NW    = IDX_W + 1;
    localparam int OW    = IDX_W + 3;
    localparam int SW    = IDX_W + 4;
    localparam int CMPW  = (POS_W > NW) ? POS_W : NW;
    localparam logic [OW-1:0] LIM = OW'(4 * MAX_POINTS);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_READ = 8'b0000_0010,
        S_CMP  = 8'b0000_0100,
        S_STEP = 8'b0000_1000,
        S_FIN  = 8'b0001_0000,
        S_PL   = 8'b0010_0000,
        S_PR   = 8'b0100_0000,
        S_PD   = 8'b1000_0000
    } t_state;

    typedef enum logic [6:0] {
        P_SELF  = 7'b000_0001,
        P_NEXT  = 7'b000_0010,
        P_PREV  = 7'b000_0100,
        P_EXP   = 7'b000_1000,
        P_BIN   = 7'b001_0000,
        P_DN    = 7'b010_0000,
        P_SPLIT = 7'b100_0000
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic                 r_out_valid, n_out_valid;
    logic [IDX_W-1:0]     r_i, n_i;
    logic [CODE_BITS-1:0] r_code_i, n_code_i;
    logic                 r_dneg, n_dneg;
    logic [KEY_W-1:0]     r_bound, n_bound;
    logic [OW-1:0]        r_lmax, n_lmax;
    logic [OW-1:0]        r_l, n_l;
    logic [OW-1:0]        r_t, n_t;
    logic [OW-1:0]        r_s, n_s;
    logic [IDX_W-1:0]     r_split, n_split;
    logic                 r_lleaf, n_lleaf;
    logic                 r_rleaf, n_rleaf;
    logic [PRIM_W-1:0]    r_prim_l, n_prim_l;
    t_out_item            r_out, n_out;

    logic [OW-1:0]        off;
    logic                 neg;
    logic signed [SW-1:0] i_s;
    logic signed [SW-1:0] off_s;
    logic signed [SW-1:0] b_s;
    logic signed [SW-1:0] n_s_ext;
    logic                 in_range;
    logic [CMPW-1:0]      pos_w;
    logic [CMPW-1:0]      n_m1;
    logic                 key_gt;
    logic [OW-1:0]        lmax2;
    logic [OW-1:0]        l_new;
    logic [OW-1:0]        t_new;
    logic signed [SW-1:0] l_s;
    logic signed [SW-1:0] s_s;
    logic signed [SW-1:0] j_s;
    logic signed [SW-1:0] lo_s;
    logic signed [SW-1:0] hi_s;
    logic signed [SW-1:0] sp_s;
    logic [CMPW-1:0]      node_w;
    logic [CMPW-1:0]      left_w;
    logic [CMPW-1:0]      right_w;
    logic [IDX_W-1:0]     split_p1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= P_SELF;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_code_i <= n_code_i;
        r_dneg   <= n_dneg;
        r_bound  <= n_bound;
        r_lmax   <= n_lmax;
        r_l      <= n_l;
        r_t      <= n_t;
        r_s      <= n_s;
        r_split  <= n_split;
        r_lleaf  <= n_lleaf;
        r_rleaf  <= n_rleaf;
        r_prim_l <= n_prim_l;
        r_out    <= n_out;
    end

    // Probe target for the current phase.
    always_comb begin
        off = '0;
        neg = 1'b0;
        unique case (r_phase)
            P_SELF: begin
                off = '0;
            end
            P_NEXT: begin
                off = OW'(1);
            end
            P_PREV: begin
                off = OW'(1);
                neg = 1'b1;
            end
            P_EXP: begin
                off = r_lmax;
                neg = r_dneg;
            end
            P_BIN: begin
                off = r_l + r_t;
                neg = r_dneg;
            end
            P_DN: begin
                off = r_l;
                neg = r_dneg;
            end
            P_SPLIT: begin
                off = r_s + r_t;
                neg = r_dneg;
            end
            default: begin
                off = '0;
            end
        endcase
    end

    assign i_s      = $signed(SW'(r_i));
    assign off_s    = $signed(SW'(off));
    assign n_s_ext  = $signed(SW'(i_n));
    assign b_s      = neg ? (i_s - off_s) : (i_s + off_s);
    assign in_range = !b_s[SW-1] && (b_s < n_s_ext);

    assign o_code_raddr     = b_s[IDX_W-1:0];
    assign o_probe.issue    = (r_state == S_READ);
    assign o_probe.in_range = in_range;
    assign o_i              = r_i;
    assign o_code_i         = r_code_i;

    assign split_p1     = r_split + IDX_W'(1);
    assign o_prim_raddr = (r_state == S_PL) ? r_split : split_p1;

    assign pos_w  = CMPW'(i_in.payload.position);
    assign n_m1   = CMPW'(i_n) - CMPW'(1);
    assign key_gt = (i_key > r_bound);
    assign lmax2  = r_lmax << 1;
    assign l_new  = key_gt ? (r_l + r_t) : r_l;
    assign t_new  = r_t >> 1;

    // Node range and split clamp.
    always_comb begin
        l_s  = $signed(SW'(r_l));
        s_s  = $signed(SW'(r_s));
        j_s  = r_dneg ? (i_s - l_s) : (i_s + l_s);
        lo_s = r_dneg ? j_s : i_s;
        hi_s = r_dneg ? i_s : j_s;
        sp_s = r_dneg ? (i_s - s_s - SW'(1)) : (i_s + s_s);
        if (sp_s < lo_s) begin
            sp_s = lo_s;
        end
        if (sp_s > hi_s - SW'(1)) begin
            sp_s = hi_s - SW'(1);
        end
    end

    assign node_w  = CMPW'(r_i);
    assign left_w  = CMPW'(r_split);
    assign right_w = CMPW'(split_p1);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_out_valid = r_out_valid;
        n_i         = r_i;
        n_code_i    = r_code_i;
        n_dneg      = r_dneg;
        n_bound     = r_bound;
        n_lmax      = r_lmax;
        n_l         = r_l;
        n_t         = r_t;
        n_s         = r_s;
        n_split     = r_split;
        n_lleaf     = r_lleaf;
        n_rleaf     = r_rleaf;
        n_prim_l    = r_prim_l;
        n_out       = r_out;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid && (i_in.payload.opcode == OP_BUILD) && (pos_w < n_m1)) begin
                    n_i     = pos_w[IDX_W-1:0];
                    n_phase = P_SELF;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                n_state = S_READ;
                unique case (r_phase)
                    P_SELF: begin
                        n_code_i = i_code_rdata;
                        n_phase  = P_NEXT;
                    end
                    P_NEXT: begin
                        n_bound = i_key;
                        n_phase = P_PREV;
                    end
                    P_PREV: begin
                        n_dneg  = (r_bound < i_key);
                        n_bound = (r_bound < i_key) ? r_bound : i_key;
                        n_lmax  = OW'(2);
                        n_phase = P_EXP;
                    end
                    P_EXP: begin
                        n_l = '0;
                        if (key_gt && (lmax2 < LIM)) begin
                            n_lmax = lmax2;
                        end else begin
                            n_t     = key_gt ? r_lmax : (r_lmax >> 1);
                            n_phase = P_BIN;
                        end
                    end
                    P_BIN: begin
                        n_l = l_new;
                        n_t = t_new;
                        if (t_new == '0) begin
                            if (l_new == '0) begin
                                n_dneg = 1'b0;
                                n_l    = OW'(1);
                            end
                            n_phase = P_DN;
                        end
                    end
                    P_DN: begin
                        n_bound = i_key;
                        n_t     = (r_l + OW'(1)) >> 1;
                        n_s     = '0;
                        n_phase = P_SPLIT;
                    end
                    P_SPLIT: begin
                        if (key_gt) begin
                            n_s = r_s + r_t;
                        end
                        if (r_t > OW'(1)) begin
                            n_t = (r_t + OW'(1)) >> 1;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_FIN: begin
                n_split = sp_s[IDX_W-1:0];
                n_lleaf = (sp_s == lo_s);
                n_rleaf = (sp_s + SW'(1) == hi_s);
                n_state = S_PL;
            end
            S_PL: begin
                n_state = S_PR;
            end
            S_PR: begin
                n_prim_l = i_prim_rdata;
                n_state  = S_PD;
            end
            S_PD: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out.node_index      = node_w[POS_W-1:0];
                    n_out.left_index      = left_w[POS_W-1:0];
                    n_out.left_is_leaf    = r_lleaf;
                    n_out.right_index     = right_w[POS_W-1:0];
                    n_out.right_is_leaf   = r_rleaf;
                    n_out.left_primitive  = r_lleaf ? r_prim_l : '0;
                    n_out.right_primitive = r_rleaf ? i_prim_rdata : '0;
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

// File: hw/rtl/radix_tree_node_builder_unit.sv
// ----------------------------------------------------------------------------
// Radix tree node builder
// Builds internal nodes of a binary radix tree from sorted Morton codes.
// ----------------------------------------------------------------------------
//   channel  direction  contents
//   i_in     in         opcode, position, morton_code, primitive_id
//   o_out    out        node_index, children, leaf flags, leaf primitives
//   apb      in/out     point_count at register index 0
//
// A load is written to both memories as it is accepted. A build probes code
// memory via read, compare and step states: three probes for the node and its
// neighbours, up to log2(N) each for range bound and length, one for the far
// end, up to log2(N) for the split; finish, primitive-read and output states
// close the node. Reset is synchronous and clears control only. A result waits
// in the output register; the next build stalls at its end until it is taken.
// ----------------------------------------------------------------------------
module radix_tree_node_builder_unit #(
    parameter int MAX_POINTS = 1024,
    parameter int CODE_BITS  = 30
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rtnb_in_if.sink                     i_in,
    rtnb_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rtnb_pkg::APB_AW-1:0] paddr,
    input  logic [rtnb_pkg::APB_DW-1:0] pwdata,
    output logic [rtnb_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import rtnb_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int NW    = IDX_W + 1;
    localparam int NCW   = (PC_W > NW) ? PC_W : NW;
    localparam int PCW   = (POS_W > NW) ? POS_W : NW;
    localparam int CXW   = (CODE_IN_W > CODE_BITS) ? CODE_IN_W : CODE_BITS;

    logic [PC_W-1:0]      r_point_count;
    logic [NCW-1:0]       pc_w;
    logic [NCW-1:0]       n_w;
    logic [NW-1:0]        n_active;
    logic [PCW-1:0]       pos_w;
    logic [CXW-1:0]       code_w;
    logic                 we;
    logic [IDX_W-1:0]     code_raddr;
    logic [CODE_BITS-1:0] code_rdata;
    logic [IDX_W-1:0]     prim_raddr;
    logic [PRIM_W-1:0]    prim_rdata;
    t_probe               probe;
    logic [IDX_W-1:0]     node_i;
    logic [CODE_BITS-1:0] code_i;
    logic [KEY_W-1:0]     key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= PC_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_POINT_COUNT)) begin
            r_point_count <= pwdata[PC_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_POINT_COUNT) ? APB_DW'(r_point_count) : '0;

    assign pc_w = NCW'(r_point_count);

    always_comb begin
        if (pc_w < NCW'(2)) begin
            n_w = NCW'(2);
        end else if (pc_w > NCW'(MAX_POINTS)) begin
            n_w = NCW'(MAX_POINTS);
        end else begin
            n_w = pc_w;
        end
    end

    assign n_active = n_w[NW-1:0];

    assign pos_w  = PCW'(i_in.payload.position);
    assign code_w = CXW'(i_in.payload.morton_code);
    assign we     = i_in.valid && i_in.ready && (i_in.payload.opcode == OP_LOAD)
                    && (pos_w < PCW'(MAX_POINTS));

    rtnb_ram #(
        .WIDTH (CODE_BITS),
        .DEPTH (MAX_POINTS)
    ) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (pos_w[IDX_W-1:0]),
        .i_wdata (code_w[CODE_BITS-1:0]),
        .i_raddr (code_raddr),
        .o_rdata (code_rdata)
    );

    rtnb_ram #(
        .WIDTH (PRIM_W),
        .DEPTH (MAX_POINTS)
    ) u_prim_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (pos_w[IDX_W-1:0]),
        .i_wdata (i_in.payload.primitive_id),
        .i_raddr (prim_raddr),
        .o_rdata (prim_rdata)
    );

    rtnb_prefix_unit #(
        .IDX_W     (IDX_W),
        .CODE_BITS (CODE_BITS)
    ) u_prefix (
        .i_clk    (i_clk),
        .i_probe  (probe),
        .i_a      (node_i),
        .i_b      (code_raddr),
        .i_code_a (code_i),
        .i_code_b (code_rdata),
        .o_key    (key)
    );

    rtnb_sequencer #(
        .MAX_POINTS (MAX_POINTS),
        .CODE_BITS  (CODE_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_n          (n_active),
        .i_in         (i_in),
        .o_out        (o_out),
        .o_code_raddr (code_raddr),
        .i_code_rdata (code_rdata),
        .o_prim_raddr (prim_raddr),
        .i_prim_rdata (prim_rdata),
        .o_probe      (probe),
        .o_i          (node_i),
        .o_code_i     (code_i),
        .i_key        (key)
    );

    a_left_prim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.payload.left_is_leaf) |-> (o_out.payload.left_primitive == '0))
        else $error("left primitive set for an internal child");

    a_right_prim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.payload.right_is_leaf) |-> (o_out.payload.right_primitive == '0))
        else $error("right primitive set for an internal child");

    a_children_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
            (o_out.payload.right_index == o_out.payload.left_index + POS_W'(1)))
        else $error("children of a node are not adjacent");

endmodule

// File: tb/radix_tree_node_builder_unit_tb.sv
// ----------------------------------------------------------------------------
// Radix tree node builder testbench
// Loads sorted Morton codes, builds internal nodes at several point counts
// and checks every reported child pair against a behavioural tree builder
// kept inside the bench, with random idling on both channels.
// ----------------------------------------------------------------------------
module radix_tree_node_builder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rtnb_pkg::*;

    localparam int MAX_POINTS  = 1024;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_WAIT  = 200;
    localparam int ITEM_TARGET = 1200;
    localparam int FIXED_PHASES = 5;

    localparam logic [APB_AW-1:0] ADDR_POINT_COUNT = {REG_POINT_COUNT, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_SPARE       = {~REG_POINT_COUNT, 2'b00};

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    rtnb_in_if  in_bus ();
    rtnb_out_if out_bus ();

    radix_tree_node_builder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [CODE_IN_W-1:0] code_mem [MAX_POINTS];
    logic [PRIM_W-1:0]    prim_mem [MAX_POINTS];
    logic [PC_W-1:0]      point_count_q;

    t_in_item  queued_requests [$];
    t_out_item expected_nodes [$];

    int  error_count = 0;
    int  queued_items = 0;
    int  nodes_seen = 0;
    int  cycle_count = 0;
    int  quiet_left = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_left = 0;
    bit  in_taken = 1'b0;
    bit  out_taken = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int active_points(logic [PC_W-1:0] pc);
        if (pc < 2) return 2;
        if (pc > MAX_POINTS) return MAX_POINTS;
        return int'(pc);
    endfunction

    function automatic int lead_zeros(logic [63:0] v);
        int c;
        c = 0;
        while (c < 64 && !v[63-c]) c++;
        return c;
    endfunction

    function automatic int common_prefix(int n, int a, int b);
        logic [63:0] diff;
        if (a < 0 || a >= n || b < 0 || b >= n) return -1;
        diff = {34'd0, code_mem[a] ^ code_mem[b]};
        if (diff != 0) return lead_zeros(diff);
        return 64 + lead_zeros({32'd0, 32'(a ^ b)});
    endfunction

    function automatic void predict_node(int i);
        int n, dir, dmin, lmax, len, t, far, lo, hi, dnode, s, split;
        bit lleaf, rleaf;
        t_out_item node;
        n = active_points(point_count_q);
        if (i >= n - 1) return;
        dir = (common_prefix(n, i, i + 1) - common_prefix(n, i, i - 1) < 0) ? -1 : 1;
        dmin = common_prefix(n, i, i - dir);
        lmax = 2;
        while (lmax < 4 * MAX_POINTS && common_prefix(n, i, i + lmax * dir) > dmin)
            lmax *= 2;
        len = 0;
        for (t = lmax / 2; t > 0; t /= 2)
            if (common_prefix(n, i, i + (len + t) * dir) > dmin) len += t;
        if (len == 0) begin
            dir = 1;
            len = 1;
        end
        far = i + len * dir;
        lo = (dir > 0) ? i : far;
        hi = (dir > 0) ? far : i;
        dnode = common_prefix(n, i, far);
        s = 0;
        t = len;
        do begin
            t = (t + 1) >> 1;
            if (common_prefix(n, i, i + (s + t) * dir) > dnode) s += t;
        end while (t > 1);
        split = i + s * dir + ((dir < 0) ? -1 : 0);
        if (split < lo) split = lo;
        if (split > hi - 1) split = hi - 1;
        lleaf = (split == lo);
        rleaf = (split + 1 == hi);
        node.node_index      = POS_W'(i);
        node.left_index      = POS_W'(split);
        node.left_is_leaf    = lleaf;
        node.right_index     = POS_W'(split + 1);
        node.right_is_leaf   = rleaf;
        node.left_primitive  = lleaf ? prim_mem[split] : '0;
        node.right_primitive = rleaf ? prim_mem[split + 1] : '0;
        expected_nodes = {expected_nodes, node};
    endfunction

    function automatic void apply_item(t_in_item item);
        if (item.opcode == OP_LOAD) begin
            code_mem[item.position] = item.morton_code;
            prim_mem[item.position] = item.primitive_id;
        end else begin
            predict_node(int'(item.position));
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    function automatic void check_node(t_out_item got);
        t_out_item want;
        if (expected_nodes.size() == 0) begin
            $error("node_index: expected no result, got %0d", got.node_index);
            error_count++;
            return;
        end
        want = expected_nodes.pop_front();
        check_field("node_index", 32'(want.node_index), 32'(got.node_index));
        check_field("left_index", 32'(want.left_index), 32'(got.left_index));
        check_field("left_is_leaf", 32'(want.left_is_leaf), 32'(got.left_is_leaf));
        check_field("right_index", 32'(want.right_index), 32'(got.right_index));
        check_field("right_is_leaf", 32'(want.right_is_leaf), 32'(got.right_is_leaf));
        check_field("left_primitive", 32'(want.left_primitive),
                    32'(got.left_primitive));
        check_field("right_primitive", 32'(want.right_primitive),
                    32'(got.right_primitive));
    endfunction

    function automatic int idle_length();
        int r;
        if (quiet_left > 0) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        in_taken = 1'b0;
        out_taken = 1'b0;
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready) begin
                in_taken = 1'b1;
                apply_item(in_bus.payload);
            end
            if (out_bus.valid && out_bus.ready) begin
                out_taken = 1'b1;
                nodes_seen++;
                check_node(out_bus.payload);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (quiet_left > 0) quiet_left--;
        else if ($urandom_range(0, 499) == 0) quiet_left = $urandom_range(100, 300);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL radix_tree_node_builder_unit");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_taken) begin
            if (in_taken) send_gap = idle_length();
            if (send_gap > 0) begin
                send_gap--;
                in_bus.valid <= 1'b0;
            end else if (queued_requests.size() > 0) begin
                in_bus.payload <= queued_requests.pop_front();
                in_bus.valid <= 1'b1;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_taken) begin
                recv_gap = idle_length();
                if (nodes_seen == 25 || nodes_seen == 200) hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    task automatic queue_load(int pos, logic [CODE_IN_W-1:0] code, logic [PRIM_W-1:0] prim);
        t_in_item item;
        item.opcode       = OP_LOAD;
        item.position     = POS_W'(pos);
        item.morton_code  = code;
        item.primitive_id = prim;
        queued_requests = {queued_requests, item};
        queued_items++;
    endtask

    task automatic queue_build(int pos);
        t_in_item item;
        item.opcode       = OP_BUILD;
        item.position     = POS_W'(pos);
        item.morton_code  = CODE_IN_W'($urandom);
        item.primitive_id = PRIM_W'($urandom);
        queued_requests = {queued_requests, item};
        queued_items++;
    endtask

    task automatic settle();
        while (queued_requests.size() != 0 || in_bus.valid || expected_nodes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr[APB_AW-1] == REG_POINT_COUNT) point_count_q = data[PC_W-1:0];
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic load_sorted(int n);
        int mode, width;
        logic [30:0] acc;
        logic [29:0] mask;
        logic [CODE_IN_W-1:0] code;
        mode = $urandom_range(0, 7);
        width = $urandom_range(0, 30 - $clog2(n));
        if (mode == 0) width = $urandom_range(0, 2);
        mask = (30'd1 << width) - 30'd1;
        acc = 31'($urandom & mask);
        for (int k = 0; k < n; k++) begin
            if (mode == 1) code = CODE_IN_W'($urandom);
            else code = acc[30] ? '1 : acc[29:0];
            queue_load(k, code, PRIM_W'($urandom));
            acc = acc + 31'($urandom & mask);
        end
    endtask

    task automatic run_phase(logic [PC_W-1:0] cfg, bit refill);
        int n, r, builds;
        settle();
        apb_write(ADDR_POINT_COUNT, APB_DW'(cfg));
        n = active_points(cfg);
        if (refill) load_sorted(n);
        builds = (n > 28) ? 60 : 2 * n + 4;
        for (int b = 0; b < builds; b++) begin
            r = $urandom_range(0, 19);
            if (r == 0) queue_build($urandom_range(n - 1, MAX_POINTS - 1));
            else if (r == 1) queue_load($urandom_range(0, MAX_POINTS - 1),
                                        CODE_IN_W'($urandom), PRIM_W'($urandom));
            else if (r == 2) queue_build(0);
            else if (r == 3) queue_build(n - 2);
            else queue_build($urandom_range(0, n - 2));
        end
    endtask

    initial begin
        logic [CODE_IN_W-1:0] corner_codes [8];
        int phase;
        logic [PC_W-1:0] cfg;
        corner_codes = '{30'h0000001, 30'h0000001, 30'h0000001, 30'h0000002,
                         30'h1000000, 30'h1000000, 30'h2AAAAAAA, 30'h3FFFFFFF};
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        point_count_q = PC_RESET;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        queue_load(0, '0, '0);
        queue_load(1, '1, '1);
        queue_build(0);
        queue_build(1);
        queue_build(MAX_POINTS - 1);
        settle();
        apb_write(ADDR_SPARE, 32'd5);
        apb_write(ADDR_POINT_COUNT, 32'd8);
        for (int k = 0; k < 8; k++)
            queue_load(k, corner_codes[k], PRIM_W'(10'h155 ^ k));
        for (int k = 0; k < 8; k++)
            queue_build(k);
        queue_load(2, '1, 10'h2AA);
        queue_build(1);
        queue_build(2);

        phase = 0;
        while (phase < FIXED_PHASES || queued_items < ITEM_TARGET) begin
            unique case (phase)
                0: run_phase(11'd0, 1'b1);
                1: run_phase(11'd1, 1'b1);
                3: run_phase(11'd1024, 1'b1);
                4: run_phase(11'd2047, 1'b0);
                default: begin
                    if ($urandom_range(0, 5) == 0) cfg = PC_W'($urandom_range(65, 300));
                    else cfg = PC_W'($urandom_range(2, 64));
                    run_phase(cfg, 1'b1);
                end
            endcase
            phase++;
        end
        settle();

        if (error_count == 0) begin
            $display("PASS radix_tree_node_builder_unit");
        end else begin
            $display("FAIL radix_tree_node_builder_unit");
        end
        $finish;
    end

endmodule
